// ----- sv/quarter_hour_sensor_averager_macros.svh -----
// assertion macros for the quarter-hour sensor averager
// no dependencies; taken in by files that carry concurrent checks
`ifndef QUARTER_HOUR_SENSOR_AVERAGER_MACROS_SVH
`define QUARTER_HOUR_SENSOR_AVERAGER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define QHSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define QHSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QHSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define QHSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/qhsa_pkg.sv -----
// shared constants, command codes and control structs of the averager
// no dependencies
package qhsa_pkg;

    localparam int HISTORY_DEPTH_DEF = 96;
    localparam int COUNT_BITS_DEF    = 16;

    localparam int CMD_BITS      = 2;
    localparam int QUARTER_BITS  = 2;
    localparam int TEMP_BITS     = 16;
    localparam int HUMI_BITS     = 14;
    localparam int RUN_BITS      = 8;
    localparam int AGE_BITS      = 7;
    localparam int MEAN_RUN_BITS = 15;
    localparam int HELD_OUT_BITS = 7;
    localparam int OPEN_Q_BITS   = 3;

    // quotient digits per division, every mean magnitude stays below 2^16
    localparam int QUO_BITS = 16;

    localparam int ENTRY_BITS = TEMP_BITS + HUMI_BITS + MEAN_RUN_BITS;

    localparam logic [CMD_BITS-1:0] CMD_CLIMATE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_RUN     = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ    = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_NONE    = 2'd3;

    localparam logic [OPEN_Q_BITS-1:0] NO_QUARTER = 3'd4;

    typedef struct packed {
        logic start;
        logic negate;
    } qhsa_div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } qhsa_div_stat_t;

endpackage

// ----- sv/qhsa_if.sv -----
// request and response channel interfaces of the averager
// depends on qhsa_pkg
interface qhsa_req_if;
    logic                                 valid;
    logic                                 ready;
    logic        [qhsa_pkg::CMD_BITS-1:0]     command;
    logic        [qhsa_pkg::QUARTER_BITS-1:0] quarter;
    logic signed [qhsa_pkg::TEMP_BITS-1:0]    temperature;
    logic        [qhsa_pkg::HUMI_BITS-1:0]    humidity;
    logic        [qhsa_pkg::RUN_BITS-1:0]     run_mode;
    logic        [qhsa_pkg::AGE_BITS-1:0]     read_age;

    modport source (output valid, command, quarter, temperature, humidity, run_mode,
                    read_age, input ready);
    modport sink (input valid, command, quarter, temperature, humidity, run_mode,
                  read_age, output ready);
endinterface

interface qhsa_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  entry_valid;
    logic signed [qhsa_pkg::TEMP_BITS-1:0]     mean_temperature;
    logic        [qhsa_pkg::HUMI_BITS-1:0]     mean_humidity;
    logic        [qhsa_pkg::MEAN_RUN_BITS-1:0] mean_run;
    logic        [qhsa_pkg::HELD_OUT_BITS-1:0] entries_held;
    logic        [qhsa_pkg::OPEN_Q_BITS-1:0]   open_quarter;

    modport source (output valid, entry_valid, mean_temperature, mean_humidity, mean_run,
                    entries_held, open_quarter, input ready);
    modport sink (input valid, entry_valid, mean_temperature, mean_humidity, mean_run,
                  entries_held, open_quarter, output ready);
endinterface

// ----- sv/quarter_hour_sensor_averager.sv -----
// top level of the quarter-hour sensor averager
// depends on qhsa_pkg, qhsa_if, qhsa_ram, qhsa_div and the assertion macro header
//
// usage
//   request words carry a command, the quarter of the hour and the sample fields.
//   a climate word adds temperature and humidity to the open quarter, a run word
//   adds a run-mode sample; neither gives a response. a read word returns one
//   history entry by age, oldest first, on the response channel. command 3 is
//   dropped.
//   the very first sample closes nothing and latches its quarter. a sample tagged with another
//   quarter first closes the open one: three means go through one bit-serial
//   divider in turn (load, quotient bits, hand-over), and are written
//   to the history ring.
// timing
//   sample in the open quarter: taken in idle, ready stays high
//   sample that closes a quarter: accept, three divisions in the serial divider,
//   store; ready is low until the store is done
//   read: ram read at acceptance, response register loaded in the read-out state
//   once it is free; ready is back when that register is loaded
// reset
//   sums, counts, ring pointers cleared, open quarter set to none; the ring
//   itself is not cleared, entries beyond the held count are never returned
// stall
//   a read response waits in the output register; further samples are still
//   taken meanwhile, the next read waits until the receiver takes the word
`include "quarter_hour_sensor_averager_macros.svh"
module quarter_hour_sensor_averager #(
    parameter int HISTORY_DEPTH = qhsa_pkg::HISTORY_DEPTH_DEF,
    parameter int COUNT_BITS    = qhsa_pkg::COUNT_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    qhsa_req_if.sink  request,
    qhsa_rsp_if.source response
);

    // widths follow the sample widths and the saturating count
    localparam int SLOT_BITS = $clog2(HISTORY_DEPTH);
    localparam int HELD_BITS = $clog2(HISTORY_DEPTH + 1);
    localparam int LW = ((HELD_BITS > qhsa_pkg::AGE_BITS) ? HELD_BITS
                                                            : qhsa_pkg::AGE_BITS) + 1;
    localparam int TS_W  = qhsa_pkg::TEMP_BITS + COUNT_BITS;
    localparam int HS_W  = qhsa_pkg::HUMI_BITS + COUNT_BITS;
    localparam int RS_W  = qhsa_pkg::RUN_BITS + COUNT_BITS;
    localparam int DVD_W = COUNT_BITS + qhsa_pkg::QUO_BITS - 1;
    localparam int TB    = qhsa_pkg::TEMP_BITS;
    localparam int HB    = qhsa_pkg::HUMI_BITS;
    localparam int MRB   = qhsa_pkg::MEAN_RUN_BITS;
    localparam int EB    = qhsa_pkg::ENTRY_BITS;

    // controller states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CLOSE  = 2'd1;
    localparam logic [1:0] S_STORE  = 2'd2;
    localparam logic [1:0] S_RD_OUT = 2'd3;

    // division phases while closing a quarter
    localparam logic [1:0] PH_TEMP = 2'd0;
    localparam logic [1:0] PH_HUMI = 2'd1;
    localparam logic [1:0] PH_RUN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       div_start_reg, div_start_next;

    // running accumulation of the open quarter
    logic signed [TS_W-1:0]       temp_sum_reg, temp_sum_next;
    logic [HS_W-1:0]              humi_sum_reg, humi_sum_next;
    logic [COUNT_BITS-1:0]        clim_cnt_reg, clim_cnt_next;
    logic [RS_W-1:0]              run_sum_reg, run_sum_next;
    logic [COUNT_BITS-1:0]        run_cnt_reg, run_cnt_next;
    logic [SLOT_BITS-1:0]         slot_reg, slot_next;
    logic [HELD_BITS-1:0]         held_reg, held_next;
    logic [qhsa_pkg::OPEN_Q_BITS-1:0] cur_q_reg, cur_q_next;

    // sample that closed the quarter, applied once the means are stored
    logic                              pend_run_reg, pend_run_next;
    logic [qhsa_pkg::QUARTER_BITS-1:0] pend_q_reg, pend_q_next;
    logic signed [TB-1:0]              pend_t_reg, pend_t_next;
    logic [HB-1:0]                     pend_h_reg, pend_h_next;
    logic [qhsa_pkg::RUN_BITS-1:0]     pend_r_reg, pend_r_next;

    // means of the quarter being closed
    logic [TB-1:0]  mean_t_reg, mean_t_next;
    logic [HB-1:0]  mean_h_reg, mean_h_next;
    logic [MRB-1:0] mean_r_reg, mean_r_next;

    logic rd_ok_reg, rd_ok_next;

    // response output register
    logic                                  rsp_valid_reg, rsp_valid_next;
    logic                                  rsp_ev_reg, rsp_ev_next;
    logic [TB-1:0]                         rsp_t_reg, rsp_t_next;
    logic [HB-1:0]                         rsp_h_reg, rsp_h_next;
    logic [MRB-1:0]                        rsp_r_reg, rsp_r_next;
    logic [qhsa_pkg::HELD_OUT_BITS-1:0]    rsp_held_reg, rsp_held_next;
    logic [qhsa_pkg::OPEN_Q_BITS-1:0]      rsp_q_reg, rsp_q_next;

    logic                        accept;
    logic                        is_sample;
    logic                        needs_close;
    logic [LW-1:0]               age_l, held_l, slot_l, depth_l, base_l, idx_l;
    logic                        age_ok;
    logic                        ram_we, ram_re;
    logic [SLOT_BITS-1:0]        ram_raddr;
    logic [EB-1:0]               ram_rdata;
    logic [TS_W-1:0]             temp_mag;
    logic [DVD_W-1:0]            run_ext, run_x100;
    logic [DVD_W-1:0]            div_dividend;
    logic [COUNT_BITS-1:0]       div_divisor;
    qhsa_pkg::qhsa_div_ctl_t     div_ctl;
    qhsa_pkg::qhsa_div_stat_t    div_stat;
    logic [qhsa_pkg::QUO_BITS-1:0] div_quo;

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;

    assign is_sample   = (request.command == qhsa_pkg::CMD_CLIMATE) ||
                         (request.command == qhsa_pkg::CMD_RUN);
    // a new quarter tag closes the open quarter, unless none was seen yet
    assign needs_close = is_sample && (cur_q_reg != qhsa_pkg::NO_QUARTER) &&
                         (cur_q_reg != {1'b0, request.quarter});

    // ring address of an entry by age: write slot minus held count plus age
    always_comb
    begin
        age_l   = LW'(request.read_age);
        held_l  = LW'(held_reg);
        slot_l  = LW'(slot_reg);
        depth_l = LW'(HISTORY_DEPTH);
        age_ok  = (age_l < held_l);
        if (slot_l >= held_l)
        begin
            base_l = slot_l - held_l;
        end
        else
        begin
            base_l = slot_l + depth_l - held_l;
        end
        idx_l = base_l + age_l;
        if (idx_l >= depth_l)
        begin
            idx_l = idx_l - depth_l;
        end
    end

    assign ram_raddr = idx_l[SLOT_BITS-1:0];
    assign ram_re    = accept && (request.command == qhsa_pkg::CMD_READ);
    assign ram_we    = (state_reg == S_STORE);

    qhsa_ram #(
        .WIDTH (EB),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata ({mean_t_reg, mean_h_reg, mean_r_reg}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // divider operands: magnitude of the temperature sum, humidity sum,
    // run sum scaled by 100 as 64 + 32 + 4
    assign temp_mag = temp_sum_reg[TS_W-1] ? TS_W'(-temp_sum_reg) : TS_W'(temp_sum_reg);
    assign run_ext  = DVD_W'(run_sum_reg);
    assign run_x100 = (run_ext << 6) + (run_ext << 5) + (run_ext << 2);

    always_comb
    begin
        div_ctl.start  = div_start_reg;
        div_ctl.negate = 1'b0;
        case (phase_reg)
            PH_TEMP:
            begin
                div_dividend   = temp_mag[DVD_W-1:0];
                div_divisor    = clim_cnt_reg;
                div_ctl.negate = temp_sum_reg[TS_W-1];
            end
            PH_HUMI:
            begin
                div_dividend = DVD_W'(humi_sum_reg);
                div_divisor  = clim_cnt_reg;
            end
            PH_RUN:
            begin
                div_dividend = run_x100;
                div_divisor  = run_cnt_reg;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    qhsa_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        div_start_next = 1'b0;
        temp_sum_next  = temp_sum_reg;
        humi_sum_next  = humi_sum_reg;
        clim_cnt_next  = clim_cnt_reg;
        run_sum_next   = run_sum_reg;
        run_cnt_next   = run_cnt_reg;
        slot_next      = slot_reg;
        held_next      = held_reg;
        cur_q_next     = cur_q_reg;
        pend_run_next  = pend_run_reg;
        pend_q_next    = pend_q_reg;
        pend_t_next    = pend_t_reg;
        pend_h_next    = pend_h_reg;
        pend_r_next    = pend_r_reg;
        mean_t_next    = mean_t_reg;
        mean_h_next    = mean_h_reg;
        mean_r_next    = mean_r_reg;
        rd_ok_next     = rd_ok_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_ev_next    = rsp_ev_reg;
        rsp_t_next     = rsp_t_reg;
        rsp_h_next     = rsp_h_reg;
        rsp_r_next     = rsp_r_reg;
        rsp_held_next  = rsp_held_reg;
        rsp_q_next     = rsp_q_reg;

        if (rsp_valid_reg && response.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (needs_close)
                    begin
                        pend_run_next  = (request.command == qhsa_pkg::CMD_RUN);
                        pend_q_next    = request.quarter;
                        pend_t_next    = request.temperature;
                        pend_h_next    = request.humidity;
                        pend_r_next    = request.run_mode;
                        phase_next     = PH_TEMP;
                        div_start_next = 1'b1;
                        state_next     = S_CLOSE;
                    end
                    else if (request.command == qhsa_pkg::CMD_CLIMATE)
                    begin
                        cur_q_next = {1'b0, request.quarter};
                        // saturated count drops the sample
                        if (clim_cnt_reg != '1)
                        begin
                            temp_sum_next = temp_sum_reg + TS_W'(request.temperature);
                            humi_sum_next = humi_sum_reg + HS_W'(request.humidity);
                            clim_cnt_next = clim_cnt_reg + 1'b1;
                        end
                    end
                    else if (request.command == qhsa_pkg::CMD_RUN)
                    begin
                        cur_q_next = {1'b0, request.quarter};
                        if (run_cnt_reg != '1)
                        begin
                            run_sum_next = run_sum_reg + RS_W'(request.run_mode);
                            run_cnt_next = run_cnt_reg + 1'b1;
                        end
                    end
                    else if (request.command == qhsa_pkg::CMD_READ)
                    begin
                        rd_ok_next = age_ok;
                        state_next = S_RD_OUT;
                    end
                end
            end
            S_CLOSE:
            begin
                if (div_stat.done)
                begin
                    case (phase_reg)
                        PH_TEMP:
                        begin
                            mean_t_next    = div_quo[TB-1:0];
                            phase_next     = PH_HUMI;
                            div_start_next = 1'b1;
                        end
                        PH_HUMI:
                        begin
                            mean_h_next    = div_quo[HB-1:0];
                            phase_next     = PH_RUN;
                            div_start_next = 1'b1;
                        end
                        default:
                        begin
                            mean_r_next = div_quo[MRB-1:0];
                            state_next  = S_STORE;
                        end
                    endcase
                end
            end
            S_STORE:
            begin
                // entry goes into the ring this cycle; sums restart with the pending sample
                temp_sum_next = '0;
                humi_sum_next = '0;
                clim_cnt_next = '0;
                run_sum_next  = '0;
                run_cnt_next  = '0;
                if (pend_run_reg)
                begin
                    run_sum_next = RS_W'(pend_r_reg);
                    run_cnt_next = COUNT_BITS'(1);
                end
                else
                begin
                    temp_sum_next = TS_W'(pend_t_reg);
                    humi_sum_next = HS_W'(pend_h_reg);
                    clim_cnt_next = COUNT_BITS'(1);
                end
                slot_next = (slot_reg == SLOT_BITS'(HISTORY_DEPTH - 1)) ? '0
                                                                        : slot_reg + 1'b1;
                if (held_reg < HELD_BITS'(HISTORY_DEPTH))
                begin
                    held_next = held_reg + 1'b1;
                end
                cur_q_next = {1'b0, pend_q_reg};
                state_next = S_IDLE;
            end
            S_RD_OUT:
            begin
                // ram data is held until the output register is free
                if (!rsp_valid_reg || response.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ev_next    = rd_ok_reg;
                    rsp_t_next     = rd_ok_reg ? ram_rdata[EB-1 -: TB] : '0;
                    rsp_h_next     = rd_ok_reg ? ram_rdata[HB+MRB-1 -: HB] : '0;
                    rsp_r_next     = rd_ok_reg ? ram_rdata[MRB-1:0] : '0;
                    rsp_held_next  = held_l[qhsa_pkg::HELD_OUT_BITS-1:0];
                    rsp_q_next     = cur_q_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_TEMP;
            div_start_reg <= 1'b0;
            temp_sum_reg  <= '0;
            humi_sum_reg  <= '0;
            clim_cnt_reg  <= '0;
            run_sum_reg   <= '0;
            run_cnt_reg   <= '0;
            slot_reg      <= '0;
            held_reg      <= '0;
            cur_q_reg     <= qhsa_pkg::NO_QUARTER;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            div_start_reg <= div_start_next;
            temp_sum_reg  <= temp_sum_next;
            humi_sum_reg  <= humi_sum_next;
            clim_cnt_reg  <= clim_cnt_next;
            run_sum_reg   <= run_sum_next;
            run_cnt_reg   <= run_cnt_next;
            slot_reg      <= slot_next;
            held_reg      <= held_next;
            cur_q_reg     <= cur_q_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_run_reg <= pend_run_next;
        pend_q_reg   <= pend_q_next;
        pend_t_reg   <= pend_t_next;
        pend_h_reg   <= pend_h_next;
        pend_r_reg   <= pend_r_next;
        mean_t_reg   <= mean_t_next;
        mean_h_reg   <= mean_h_next;
        mean_r_reg   <= mean_r_next;
        rd_ok_reg    <= rd_ok_next;
        rsp_ev_reg   <= rsp_ev_next;
        rsp_t_reg    <= rsp_t_next;
        rsp_h_reg    <= rsp_h_next;
        rsp_r_reg    <= rsp_r_next;
        rsp_held_reg <= rsp_held_next;
        rsp_q_reg    <= rsp_q_next;
    end

    assign response.valid            = rsp_valid_reg;
    assign response.entry_valid      = rsp_ev_reg;
    assign response.mean_temperature = rsp_t_reg;
    assign response.mean_humidity    = rsp_h_reg;
    assign response.mean_run         = rsp_r_reg;
    assign response.entries_held     = rsp_held_reg;
    assign response.open_quarter     = rsp_q_reg;

    // held count never passes the ring depth
    `QHSA_ASSERT_IMP(a_held_max, clk, rst_n, 1'b1,
                     held_reg <= HELD_BITS'(HISTORY_DEPTH), "held count beyond ring depth")
    // divider only runs while a quarter is being closed
    `QHSA_ASSERT_IMP(a_div_in_close, clk, rst_n, div_stat.busy,
                     state_reg == S_CLOSE, "divider busy outside close")
    // after a store a real quarter is open
    `QHSA_ASSERT_NEXT(a_store_quarter, clk, rst_n, state_reg == S_STORE,
                      cur_q_reg != qhsa_pkg::NO_QUARTER, "no open quarter after store")

endmodule

// ----- sv/qhsa_ram.sv -----
// generic single-write, single-read ram with registered read data
// depends on qhsa_pkg for default sizes
module qhsa_ram #(
    parameter int WIDTH = qhsa_pkg::ENTRY_BITS,
    parameter int DEPTH = qhsa_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/qhsa_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on qhsa_pkg (quotient width, control structs)
module qhsa_div #(
    parameter int COUNT_BITS = qhsa_pkg::COUNT_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  qhsa_pkg::qhsa_div_ctl_t                       ctl,
    input  logic [COUNT_BITS+qhsa_pkg::QUO_BITS-2:0]      dividend,
    input  logic [COUNT_BITS-1:0]                         divisor,
    output qhsa_pkg::qhsa_div_stat_t                      stat,
    output logic [qhsa_pkg::QUO_BITS-1:0]                 quotient
);

    localparam int QB     = qhsa_pkg::QUO_BITS;
    localparam int DVD_W  = COUNT_BITS + QB - 1;
    localparam int STEP_W = $clog2(QB);

    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [QB-1:0]         low_reg, low_next;
    logic [QB-1:0]         quo_reg, quo_next;
    logic [COUNT_BITS-1:0] dsr_reg, dsr_next;
    logic                  neg_reg, neg_next;
    logic                  zero_reg, zero_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  fits;

    assign trial = {rem_reg, low_reg[QB-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            // upper part of the dividend is already below the divisor
            rem_next  = {1'b0, dividend[DVD_W-1:QB]};
            low_next  = dividend[QB-1:0];
            dsr_next  = divisor;
            neg_next  = ctl.negate;
            zero_next = (divisor == '0);
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            low_next  = {low_reg[QB-2:0], 1'b0};
            quo_next  = {quo_reg[QB-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(QB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    // empty count gives a zero mean
    assign quotient  = zero_reg ? '0 : (neg_reg ? QB'(-quo_reg) : quo_reg);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- tb/qhsa_history_checker.sv -----
`timescale 1ns / 100ps
// checker for the quarter-hour sensor averager: follows both channels, predicts reads
// depends on qhsa_pkg and the request and response interfaces of qhsa_if
module qhsa_history_checker
    import qhsa_pkg::*;
#(
    parameter int DEPTH       = HISTORY_DEPTH_DEF,
    parameter int COUNT_LIMIT = (1 << COUNT_BITS_DEF) - 1
) (
    input  logic clk,
    input  logic rst_n,
    qhsa_req_if  request,
    qhsa_rsp_if  response,
    output int   failures,
    output int   outstanding,
    output int   responses_seen
);

    typedef struct packed {
        logic signed [TEMP_BITS-1:0]     temp;
        logic        [HUMI_BITS-1:0]     humi;
        logic        [MEAN_RUN_BITS-1:0] run;
    } quarter_means_t;

    typedef struct packed {
        logic                            entry_valid;
        logic signed [TEMP_BITS-1:0]     mean_temperature;
        logic        [HUMI_BITS-1:0]     mean_humidity;
        logic        [MEAN_RUN_BITS-1:0] mean_run;
        logic        [HELD_OUT_BITS-1:0] entries_held;
        logic        [OPEN_Q_BITS-1:0]   open_quarter;
    } history_word_t;

    // running totals of the open quarter
    longint temp_total;
    longint humi_total;
    longint run_total;
    int     climate_n;
    int     run_n;

    quarter_means_t ring [DEPTH];
    int             next_slot;
    int             held;
    logic [OPEN_Q_BITS-1:0] open_q;

    history_word_t awaited_entries [$];

    // close the open quarter when a sample carries another one
    function automatic void settle_quarter(input logic [QUARTER_BITS-1:0] q);
        quarter_means_t m;
        if (open_q == NO_QUARTER) begin
            open_q = {1'b0, q};
            return;
        end
        if (open_q == {1'b0, q})
            return;
        m.temp = (climate_n != 0) ? TEMP_BITS'(temp_total / climate_n) : '0;
        m.humi = (climate_n != 0) ? HUMI_BITS'(humi_total / climate_n) : '0;
        m.run  = (run_n != 0) ? MEAN_RUN_BITS'((run_total * 100) / run_n) : '0;
        ring[next_slot] = m;
        next_slot = (next_slot + 1) % DEPTH;
        if (held < DEPTH)
            held++;
        temp_total = 0;
        humi_total = 0;
        run_total  = 0;
        climate_n  = 0;
        run_n      = 0;
        open_q     = {1'b0, q};
    endfunction

    function automatic history_word_t lookup_entry(input logic [AGE_BITS-1:0] age);
        history_word_t w;
        int idx;
        w = '0;
        w.entries_held = HELD_OUT_BITS'(held);
        w.open_quarter = open_q;
        if (age < held) begin
            idx = (next_slot + DEPTH - held + age) % DEPTH;
            w.entry_valid      = 1'b1;
            w.mean_temperature = ring[idx].temp;
            w.mean_humidity    = ring[idx].humi;
            w.mean_run         = ring[idx].run;
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        history_word_t got;
        history_word_t want;
        if (!rst_n)
        begin
            temp_total = 0;
            humi_total = 0;
            run_total  = 0;
            climate_n  = 0;
            run_n      = 0;
            next_slot  = 0;
            held       = 0;
            open_q     = NO_QUARTER;
            awaited_entries.delete();
        end
        else
        begin
            if (request.valid === 1'b1 && request.ready === 1'b1)
            begin
                case (request.command)
                    CMD_CLIMATE:
                    begin
                        settle_quarter(request.quarter);
                        if (climate_n < COUNT_LIMIT)
                        begin
                            temp_total += longint'(request.temperature);
                            humi_total += longint'(request.humidity);
                            climate_n++;
                        end
                    end
                    CMD_RUN:
                    begin
                        settle_quarter(request.quarter);
                        if (run_n < COUNT_LIMIT)
                        begin
                            run_total += longint'(request.run_mode);
                            run_n++;
                        end
                    end
                    CMD_READ:
                        awaited_entries.push_back(lookup_entry(request.read_age));
                    default:
                        ;
                endcase
            end

            if (response.valid === 1'b1 && response.ready === 1'b1)
            begin
                responses_seen++;
                got.entry_valid      = response.entry_valid;
                got.mean_temperature = response.mean_temperature;
                got.mean_humidity    = response.mean_humidity;
                got.mean_run         = response.mean_run;
                got.entries_held     = response.entries_held;
                got.open_quarter     = response.open_quarter;
                if (awaited_entries.size() == 0)
                begin
                    failures++;
                    if (failures <= 50)
                        $display("%0t checker: response with no read waiting, got valid=%0b",
                                 $time, got.entry_valid);
                end
                else
                begin
                    want = awaited_entries.pop_front();
                    if (got !== want)
                    begin
                        failures++;
                        if (failures <= 50)
                            $display({"%0t checker: mismatch, expected valid=%0b temp=%0d ",
                                      "humi=%0d run=%0d held=%0d open=%0d, got valid=%0b ",
                                      "temp=%0d humi=%0d run=%0d held=%0d open=%0d"},
                                     $time, want.entry_valid, want.mean_temperature,
                                     want.mean_humidity, want.mean_run, want.entries_held,
                                     want.open_quarter, got.entry_valid,
                                     got.mean_temperature, got.mean_humidity, got.mean_run,
                                     got.entries_held, got.open_quarter);
                    end
                end
            end
        end
        outstanding = awaited_entries.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// top of the averager testbench: clock, reset, request and response stimulus, verdict
// depends on qhsa_pkg, qhsa_if, the averager rtl and qhsa_history_checker
module tb;
    import qhsa_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RANDOM_WORDS = 1090;
    // short back-to-back run of samples in one quarter
    localparam int BURST_WORDS  = 16;

    logic clk;
    logic rst_n;

    // idling off for the burst
    bit no_idle;

    int n_climate;
    int n_run;
    int n_read;
    int n_spare;

    int failures;
    int outstanding;
    int responses_seen;

    // quarter the stimulus is currently tagging samples with
    logic [QUARTER_BITS-1:0] open_q;

    qhsa_req_if request_ch ();
    qhsa_rsp_if response_ch ();

    quarter_hour_sensor_averager i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    qhsa_history_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .request        (request_ch),
        .response       (response_ch),
        .failures       (failures),
        .outstanding    (outstanding),
        .responses_seen (responses_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [HUMI_BITS-1:0] rand_humidity();
        // mostly in the physical range, sometimes above it
        if ($urandom_range(0, 4) != 0)
            return HUMI_BITS'($urandom_range(0, 10000));
        return HUMI_BITS'($urandom_range(0, (1 << HUMI_BITS) - 1));
    endfunction

    // one request word: optional gap with valid low, then hold until taken
    task automatic send_word(input logic [CMD_BITS-1:0]     cmd,
                             input logic [QUARTER_BITS-1:0] q,
                             input logic [TEMP_BITS-1:0]    t,
                             input logic [HUMI_BITS-1:0]    h,
                             input logic [RUN_BITS-1:0]     r,
                             input logic [AGE_BITS-1:0]     age);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid       <= 1'b1;
        request_ch.command     <= cmd;
        request_ch.quarter     <= q;
        request_ch.temperature <= t;
        request_ch.humidity    <= h;
        request_ch.run_mode    <= r;
        request_ch.read_age    <= age;
        do
            @(posedge clk);
        while (request_ch.ready !== 1'b1);
        case (cmd)
            CMD_CLIMATE: n_climate++;
            CMD_RUN:     n_run++;
            CMD_READ:    n_read++;
            default:     n_spare++;
        endcase
    endtask

    // fields a command ignores still get random content
    task automatic send_climate(input logic [QUARTER_BITS-1:0] q,
                                input logic [TEMP_BITS-1:0] t, input logic [HUMI_BITS-1:0] h);
        send_word(CMD_CLIMATE, q, t, h, RUN_BITS'($urandom), AGE_BITS'($urandom));
    endtask

    task automatic send_run(input logic [QUARTER_BITS-1:0] q, input logic [RUN_BITS-1:0] r);
        send_word(CMD_RUN, q, TEMP_BITS'($urandom), HUMI_BITS'($urandom), r,
                  AGE_BITS'($urandom));
    endtask

    task automatic send_read(input logic [AGE_BITS-1:0] age);
        send_word(CMD_READ, QUARTER_BITS'($urandom), TEMP_BITS'($urandom),
                  HUMI_BITS'($urandom), RUN_BITS'($urandom), age);
    endtask

    // drop valid and hold off until every read response has come back
    task automatic drain_reads();
        request_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
    endtask

    // response side: random stalls, ready held high while idling is off
    initial
    begin
        int gap;
        response_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (no_idle)
            begin
                response_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    response_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                response_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // overall limit, far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        int pick;
        // every input known from the start
        rst_n                  <= 1'b0;
        no_idle                = 1'b0;
        request_ch.valid       <= 1'b0;
        request_ch.command     <= CMD_CLIMATE;
        request_ch.quarter     <= '0;
        request_ch.temperature <= '0;
        request_ch.humidity    <= '0;
        request_ch.run_mode    <= '0;
        request_ch.read_age    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        // read before any sample: nothing held, no quarter open
        send_read(7'd0);
        // first sample latches quarter 0, extremes of both climate fields
        send_climate(2'd0, 16'sh8000, 14'd0);
        send_climate(2'd0, 16'sh7fff, 14'h3fff);
        send_run(2'd0, 8'hff);
        send_run(2'd0, 8'h00);
        // unused command, tagged with another quarter, must not close anything
        send_word(CMD_NONE, 2'd1, TEMP_BITS'($urandom), HUMI_BITS'($urandom),
                  RUN_BITS'($urandom), AGE_BITS'($urandom));
        send_read(7'd0);
        // climate sample closes quarter 0
        send_climate(2'd1, 16'sd0, 14'd10000);
        // run sample closes quarter 1, which had no run samples
        send_run(2'd2, 8'd17);
        // negative sum, truncation toward zero
        send_climate(2'd2, -16'sd3, 14'd1);
        send_climate(2'd2, -16'sd4, 14'd2);
        // reads never close a quarter
        send_read(7'd0);
        send_read(7'd1);
        send_read(7'd2);
        send_read(7'd127);
        // run sample closes quarter 2
        send_run(2'd3, 8'd1);
        send_read(7'd2);
        send_read(7'd3);
        // close a quarter with no climate samples at all
        send_run(2'd0, 8'd200);
        send_read(7'd3);
        send_read(7'd4);
        open_q = 2'd0;

        // back-to-back burst: both sample kinds in one quarter, no idling
        drain_reads();
        no_idle = 1'b1;
        for (int i = 0; i < BURST_WORDS; i++)
            send_climate(open_q, TEMP_BITS'($urandom), HUMI_BITS'($urandom));
        for (int i = 0; i < BURST_WORDS; i++)
            send_run(open_q, RUN_BITS'($urandom));
        send_read(7'd0);
        open_q = open_q + 1'b1;
        send_climate(open_q, TEMP_BITS'($urandom), rand_humidity());
        for (int age = 0; age < 6; age++)
            send_read(AGE_BITS'(age));
        no_idle = 1'b0;

        // random part: mostly samples with the odd quarter change, plus reads
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // pressure point: hold off until nothing is awaited
            if (i == RANDOM_WORDS / 2)
                drain_reads();
            // a stretch with no idling on either side
            no_idle = (i >= 300 && i < 380);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_word(CMD_NONE, QUARTER_BITS'($urandom), TEMP_BITS'($urandom),
                          HUMI_BITS'($urandom), RUN_BITS'($urandom), AGE_BITS'($urandom));
            else if (pick < 28)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_read(AGE_BITS'($urandom_range(0, HISTORY_DEPTH_DEF - 1)));
                else
                    send_read(AGE_BITS'($urandom));
            end
            else
            begin
                // quarter change: usually the next one, sometimes a jump
                if ($urandom_range(0, 99) < 25)
                    open_q = ($urandom_range(0, 3) == 0) ? QUARTER_BITS'($urandom)
                                                         : open_q + 1'b1;
                if (pick < 64)
                    send_climate(open_q, TEMP_BITS'($urandom), rand_humidity());
                else
                    send_run(open_q, RUN_BITS'($urandom));
            end
        end
        no_idle = 1'b0;

        // wind down: wait for the last responses, then a margin for strays
        drain_reads();
        repeat (100) @(posedge clk);

        $display("tb: sent %0d climate, %0d run, %0d read and %0d unused words; %0d responses",
                 n_climate, n_run, n_read, n_spare, responses_seen);
        $display({"tb: covered first-sample latch, empty quarters, unused commands, ",
                  "out-of-range reads and stalls on a %0d-entry history ring"},
                 HISTORY_DEPTH_DEF);
        if (failures == 0 && outstanding == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
